// ===== src/i2crts_pkg.sv =====
package i2crts_pkg;

    localparam int IN_W  = 40;
    localparam int OUT_W = 32;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_REQ  = 2'd1;
    localparam logic [1:0] OP_RESP = 2'd2;

    localparam logic [2:0] CMD_START  = 3'd0;
    localparam logic [2:0] CMD_STOP   = 3'd1;
    localparam logic [2:0] CMD_WRITE  = 3'd2;
    localparam logic [2:0] CMD_RD_ACK = 3'd3;
    localparam logic [2:0] CMD_RD_NAK = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NAK  = 2'd1;
    localparam logic [1:0] ST_ARB  = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic       is_read;
        logic [6:0] slave_addr;
        logic [7:0] reg_addr;
        logic [4:0] byte_count;
        logic [3:0] buf_index;
        logic [7:0] data_byte;
        logic       flag_nak;
        logic       flag_arb_lost;
        logic       flag_error;
    } t_item;

    typedef struct packed {
        logic       valid;
        logic       cmd_valid;
        logic [2:0] cmd_code;
        logic [7:0] cmd_byte;
        logic       use_mem;
        logic       rd_valid;
        logic [7:0] rd_byte;
        logic [3:0] rd_index;
        logic       xfer_done;
        logic [1:0] status;
    } t_result;

endpackage

// ===== src/i2crts_ctrl.sv =====
module i2crts_ctrl #(
    parameter int MAX_BYTES = 16,
    parameter int AW        = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  i2crts_pkg::t_item    i_item,
    output i2crts_pkg::t_result  o_res,
    output logic [AW-1:0]        o_rd_addr
);

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_START  = 4'd1;
    localparam logic [3:0] PH_ADDRW  = 4'd2;
    localparam logic [3:0] PH_REGW   = 4'd3;
    localparam logic [3:0] PH_WDATA  = 4'd4;
    localparam logic [3:0] PH_RSTART = 4'd5;
    localparam logic [3:0] PH_ADDRR  = 4'd6;
    localparam logic [3:0] PH_RDATA  = 4'd7;
    localparam logic [3:0] PH_STOP   = 4'd8;

    localparam logic [8:0] MAX_W = 9'(MAX_BYTES);

    logic [3:0] r_phase, n_phase;
    logic       r_dir_read, n_dir_read;
    logic [6:0] r_dev_addr, n_dev_addr;
    logic [7:0] r_reg_byte, n_reg_byte;
    logic [4:0] r_count, n_count;
    logic [4:0] r_pos, n_pos;
    logic [1:0] r_held, n_held;

    logic [1:0]    st;
    logic [5:0]    pos_inc;
    logic [5:0]    pos_inc2;
    logic [5:0]    count6;
    logic [4:0]    req_count;
    logic [4:0]    rd_pos;
    logic [AW+4:0] rd_pos_ext;

    i2crts_pkg::t_result res;

    assign pos_inc    = 6'(r_pos) + 6'd1;
    assign pos_inc2   = 6'(r_pos) + 6'd2;
    assign count6     = 6'(r_count);
    assign rd_pos_ext = (AW+5)'(rd_pos);
    assign o_rd_addr  = rd_pos_ext[AW-1:0];
    assign o_res      = res;

    always_comb begin
        if (i_item.flag_nak) begin
            st = i2crts_pkg::ST_NAK;
        end else if (i_item.flag_arb_lost) begin
            st = i2crts_pkg::ST_ARB;
        end else if (i_item.flag_error) begin
            st = i2crts_pkg::ST_ERR;
        end else begin
            st = i2crts_pkg::ST_DONE;
        end
    end

    always_comb begin
        if (9'(i_item.byte_count) > MAX_W) begin
            req_count = 5'(MAX_BYTES);
        end else begin
            req_count = i_item.byte_count;
        end
        if (i_item.is_read && req_count == 5'd0) begin
            req_count = 5'd1;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_dir_read = r_dir_read;
        n_dev_addr = r_dev_addr;
        n_reg_byte = r_reg_byte;
        n_count    = r_count;
        n_pos      = r_pos;
        n_held     = r_held;
        res        = '0;
        rd_pos     = 5'd0;

        if (i_item.opcode == i2crts_pkg::OP_REQ && r_phase == PH_IDLE) begin
            n_dir_read   = i_item.is_read;
            n_dev_addr   = i_item.slave_addr;
            n_reg_byte   = i_item.reg_addr;
            n_count      = req_count;
            n_pos        = 5'd0;
            n_held       = i2crts_pkg::ST_DONE;
            n_phase      = PH_START;
            res.valid    = 1'b1;
            res.cmd_valid = 1'b1;
            res.cmd_code = i2crts_pkg::CMD_START;
        end else if (i_item.opcode == i2crts_pkg::OP_RESP && r_phase != PH_IDLE) begin
            res.valid = 1'b1;
            case (r_phase)
                PH_START, PH_RSTART: begin
                    if (st != i2crts_pkg::ST_DONE) begin
                        res.xfer_done = 1'b1;
                        res.status    = st;
                        n_phase       = PH_IDLE;
                    end else begin
                        res.cmd_valid = 1'b1;
                        res.cmd_code  = i2crts_pkg::CMD_WRITE;
                        res.cmd_byte  = {r_dev_addr, (r_phase == PH_RSTART)};
                        n_phase       = (r_phase == PH_RSTART) ? PH_ADDRR : PH_ADDRW;
                    end
                end
                PH_ADDRW: begin
                    if (st != i2crts_pkg::ST_DONE) begin
                        res.cmd_valid = 1'b1;
                        res.cmd_code  = i2crts_pkg::CMD_STOP;
                        n_held        = st;
                        n_phase       = PH_STOP;
                    end else begin
                        res.cmd_valid = 1'b1;
                        res.cmd_code  = i2crts_pkg::CMD_WRITE;
                        res.cmd_byte  = r_reg_byte;
                        n_phase       = PH_REGW;
                    end
                end
                PH_REGW: begin
                    res.cmd_valid = 1'b1;
                    if (st != i2crts_pkg::ST_DONE) begin
                        res.cmd_code = i2crts_pkg::CMD_STOP;
                        n_held       = st;
                        n_phase      = PH_STOP;
                    end else if (r_dir_read) begin
                        res.cmd_code = i2crts_pkg::CMD_START;
                        n_phase      = PH_RSTART;
                    end else if (r_count == 5'd0) begin
                        res.cmd_code = i2crts_pkg::CMD_STOP;
                        n_held       = i2crts_pkg::ST_DONE;
                        n_phase      = PH_STOP;
                    end else begin
                        res.cmd_code = i2crts_pkg::CMD_WRITE;
                        res.use_mem  = 1'b1;
                        rd_pos       = 5'd0;
                        n_pos        = 5'd0;
                        n_phase      = PH_WDATA;
                    end
                end
                PH_WDATA: begin
                    res.cmd_valid = 1'b1;
                    if (st != i2crts_pkg::ST_DONE) begin
                        res.cmd_code = i2crts_pkg::CMD_STOP;
                        n_held       = st;
                        n_phase      = PH_STOP;
                    end else begin
                        n_pos = pos_inc[4:0];
                        if (pos_inc >= count6) begin
                            res.cmd_code = i2crts_pkg::CMD_STOP;
                            n_held       = i2crts_pkg::ST_DONE;
                            n_phase      = PH_STOP;
                        end else begin
                            res.cmd_code = i2crts_pkg::CMD_WRITE;
                            res.use_mem  = 1'b1;
                            rd_pos       = pos_inc[4:0];
                        end
                    end
                end
                PH_ADDRR: begin
                    res.cmd_valid = 1'b1;
                    if (st != i2crts_pkg::ST_DONE) begin
                        res.cmd_code = i2crts_pkg::CMD_STOP;
                        n_held       = st;
                        n_phase      = PH_STOP;
                    end else begin
                        n_pos        = 5'd0;
                        res.cmd_code = (r_count <= 5'd1) ? i2crts_pkg::CMD_RD_NAK
                                                         : i2crts_pkg::CMD_RD_ACK;
                        n_phase      = PH_RDATA;
                    end
                end
                PH_RDATA: begin
                    if (st != i2crts_pkg::ST_DONE) begin
                        res.xfer_done = 1'b1;
                        res.status    = st;
                        n_phase       = PH_IDLE;
                    end else begin
                        res.rd_valid  = 1'b1;
                        res.rd_byte   = i_item.data_byte;
                        res.rd_index  = r_pos[3:0];
                        res.cmd_valid = 1'b1;
                        n_pos         = pos_inc[4:0];
                        if (pos_inc >= count6) begin
                            res.cmd_code = i2crts_pkg::CMD_STOP;
                            n_held       = i2crts_pkg::ST_DONE;
                            n_phase      = PH_STOP;
                        end else begin
                            res.cmd_code = (pos_inc2 >= count6) ? i2crts_pkg::CMD_RD_NAK
                                                                : i2crts_pkg::CMD_RD_ACK;
                        end
                    end
                end
                default: begin
                    res.xfer_done = 1'b1;
                    res.status    = r_held;
                    n_phase       = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_dir_read <= 1'b0;
            r_dev_addr <= '0;
            r_reg_byte <= '0;
            r_count    <= '0;
            r_pos      <= '0;
            r_held     <= i2crts_pkg::ST_DONE;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_dir_read <= n_dir_read;
            r_dev_addr <= n_dev_addr;
            r_reg_byte <= n_reg_byte;
            r_count    <= n_count;
            r_pos      <= n_pos;
            r_held     <= n_held;
        end
    end

endmodule

// ===== src/i2c_register_transfer_sequencer_top.sv =====
// Sequences one I2C register read or write at a time over a byte-level bus controller.
// Every request (buffer load, transfer start or controller response) arrives on the slave
// stream, and each transfer start or response taken while it matters yields one result on
// the master stream: the next controller command, a received byte, or the end of the
// transfer with its status. One request is taken per clock cycle when the master side keeps
// up; each result is registered alongside the synchronous read of the write buffer memory,
// then registered again in the output register.
module i2c_register_transfer_sequencer_top #(
    parameter int MAX_BYTES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // is_read, slave_addr, reg_addr, byte_count, buf_index, data_byte, flag_nak,
    // flag_arb_lost, flag_error, zero fill.
    input  logic [i2crts_pkg::IN_W-1:0]   i_s_axis_tdata,
    // opcode.
    input  logic [1:0]                    i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // cmd_valid, cmd_code, cmd_byte, rd_valid, rd_byte, rd_index, xfer_done, status,
    // zero fill.
    output logic [i2crts_pkg::OUT_W-1:0]  o_m_axis_tdata
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam logic [8:0] MAX_W = 9'(MAX_BYTES);

    i2crts_pkg::t_item   item;
    i2crts_pkg::t_result res;
    i2crts_pkg::t_result r_s1;

    logic          accept;
    logic          s1_move;
    logic          r_s1_valid;
    logic          r_out_valid;
    logic [i2crts_pkg::OUT_W-1:0] r_out_data;
    logic [i2crts_pkg::OUT_W-1:0] n_out_data;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [AW+3:0] wr_idx_ext;
    logic          wr_en;
    logic [7:0]    r_mem_q;
    logic [7:0]    cmd_byte;
    logic [7:0]    mem [MAX_BYTES];

    assign item.opcode        = i_s_axis_tuser;
    assign item.is_read       = i_s_axis_tdata[0];
    assign item.slave_addr    = i_s_axis_tdata[7:1];
    assign item.reg_addr      = i_s_axis_tdata[15:8];
    assign item.byte_count    = i_s_axis_tdata[20:16];
    assign item.buf_index     = i_s_axis_tdata[24:21];
    assign item.data_byte     = i_s_axis_tdata[32:25];
    assign item.flag_nak      = i_s_axis_tdata[33];
    assign item.flag_arb_lost = i_s_axis_tdata[34];
    assign item.flag_error    = i_s_axis_tdata[35];

    assign s1_move         = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = i_rst_n && (!r_s1_valid || s1_move);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    i2crts_ctrl #(
        .MAX_BYTES(MAX_BYTES),
        .AW       (AW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .o_res    (res),
        .o_rd_addr(rd_addr)
    );

    assign wr_idx_ext = (AW+4)'(item.buf_index);
    assign wr_addr    = wr_idx_ext[AW-1:0];
    assign wr_en      = accept && item.opcode == i2crts_pkg::OP_LOAD
                        && 9'(item.buf_index) < MAX_W;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= item.data_byte;
        end
        if (accept) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= res.valid;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= res;
        end
    end

    assign cmd_byte   = r_s1.use_mem ? r_mem_q : r_s1.cmd_byte;
    assign n_out_data = {4'd0, r_s1.status, r_s1.xfer_done, r_s1.rd_index, r_s1.rd_byte,
                         r_s1.rd_valid, cmd_byte, r_s1.cmd_code, r_s1.cmd_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== src/i2crts_chk.sv =====
module i2crts_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [i2crts_pkg::OUT_W-1:0]  o_m_axis_tdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result shown right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_done_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[25] && (o_m_axis_tdata[0] || o_m_axis_tdata[12])))
        else $error("transfer end carries a command or a byte");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[0] |->
            o_m_axis_tdata[3:1] == 3'd0 && o_m_axis_tdata[11:4] == 8'd0)
        else $error("command fields set without a command");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[25] |-> o_m_axis_tdata[27:26] == 2'd0)
        else $error("status set before the transfer ends");

endmodule

bind i2c_register_transfer_sequencer_top i2crts_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata)
);

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int BUF_SLOTS = 16;
    localparam int IDLE_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int STALL_CYCLES = 300;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_START, SEQ_ADDR_WR, SEQ_REG_WR, SEQ_WR_DATA,
        SEQ_RESTART, SEQ_ADDR_RD, SEQ_RD_DATA, SEQ_STOP
    } t_seq_phase;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] cmd_code;
        logic [7:0] cmd_byte;
        logic       rd_valid;
        logic [7:0] rd_byte;
        logic [3:0] rd_index;
        logic       xfer_done;
        logic [1:0] status;
    } t_bus_step;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    // is_read, slave_addr, reg_addr, byte_count, buf_index, data_byte, flag_nak,
    // flag_arb_lost, flag_error, zero fill.
    logic [i2crts_pkg::IN_W-1:0]   i_s_axis_tdata;
    // opcode.
    logic [1:0]        i_s_axis_tuser;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    // cmd_valid, cmd_code, cmd_byte, rd_valid, rd_byte, rd_index, xfer_done, status,
    // zero fill.
    logic [i2crts_pkg::OUT_W-1:0]  o_m_axis_tdata;

    t_seq_phase seq_phase;
    logic       xfer_read;
    logic [6:0] xfer_dev;
    logic [7:0] xfer_reg;
    logic [4:0] xfer_total;
    logic [4:0] xfer_pos;
    logic [1:0] xfer_held;
    logic [7:0] tx_buffer [BUF_SLOTS];

    t_bus_step pending_bus_steps [$];
    int        mismatch_count = 0;
    int        work_items = 0;
    int        quiet_cycles = 0;
    int        gap_max = 5;
    int        hold_off = 0;

    i2c_register_transfer_sequencer_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int got_v, input int want_v);
        if (got_v != want_v) begin
            note_mismatch($sformatf("%s got %0d want %0d", name, got_v, want_v));
        end
    endtask

    task put_cmd(inout t_bus_step s, input logic [2:0] code, input logic [7:0] data);
        s.cmd_valid = 1'b1;
        s.cmd_code = code;
        s.cmd_byte = data;
    endtask

    task issue_stop(inout t_bus_step s, input logic [1:0] st);
        put_cmd(s, i2crts_pkg::CMD_STOP, 8'h00);
        xfer_held = st;
        seq_phase = SEQ_STOP;
    endtask

    task end_xfer(inout t_bus_step s, input logic [1:0] st);
        s.xfer_done = 1'b1;
        s.status = st;
        seq_phase = SEQ_IDLE;
    endtask

    task advance_sequencer(input i2crts_pkg::t_item it, output bit produced,
                           output t_bus_step step);
        logic [1:0] st;
        logic [4:0] n;
        step = '0;
        produced = 1'b0;
        case (it.opcode)
            i2crts_pkg::OP_LOAD: begin
                tx_buffer[it.buf_index] = it.data_byte;
                work_items++;
            end
            i2crts_pkg::OP_REQ: begin
                if (seq_phase == SEQ_IDLE) begin
                    n = it.byte_count;
                    if (int'(n) > BUF_SLOTS) n = 5'(BUF_SLOTS);
                    if (it.is_read && n == 5'd0) n = 5'd1;
                    xfer_read = it.is_read;
                    xfer_dev = it.slave_addr;
                    xfer_reg = it.reg_addr;
                    xfer_total = n;
                    xfer_pos = '0;
                    xfer_held = i2crts_pkg::ST_DONE;
                    put_cmd(step, i2crts_pkg::CMD_START, 8'h00);
                    seq_phase = SEQ_START;
                    produced = 1'b1;
                end
            end
            i2crts_pkg::OP_RESP: begin
                if (seq_phase != SEQ_IDLE) begin
                    produced = 1'b1;
                    if (it.flag_nak) st = i2crts_pkg::ST_NAK;
                    else if (it.flag_arb_lost) st = i2crts_pkg::ST_ARB;
                    else if (it.flag_error) st = i2crts_pkg::ST_ERR;
                    else st = i2crts_pkg::ST_DONE;
                    case (seq_phase)
                        SEQ_START: begin
                            if (st != i2crts_pkg::ST_DONE) begin
                                end_xfer(step, st);
                            end else begin
                                put_cmd(step, i2crts_pkg::CMD_WRITE, {xfer_dev, 1'b0});
                                seq_phase = SEQ_ADDR_WR;
                            end
                        end
                        SEQ_ADDR_WR: begin
                            if (st != i2crts_pkg::ST_DONE) begin
                                issue_stop(step, st);
                            end else begin
                                put_cmd(step, i2crts_pkg::CMD_WRITE, xfer_reg);
                                seq_phase = SEQ_REG_WR;
                            end
                        end
                        SEQ_REG_WR: begin
                            if (st != i2crts_pkg::ST_DONE) begin
                                issue_stop(step, st);
                            end else if (xfer_read) begin
                                put_cmd(step, i2crts_pkg::CMD_START, 8'h00);
                                seq_phase = SEQ_RESTART;
                            end else if (xfer_total == 5'd0) begin
                                issue_stop(step, i2crts_pkg::ST_DONE);
                            end else begin
                                xfer_pos = '0;
                                put_cmd(step, i2crts_pkg::CMD_WRITE, tx_buffer[0]);
                                seq_phase = SEQ_WR_DATA;
                            end
                        end
                        SEQ_WR_DATA: begin
                            if (st != i2crts_pkg::ST_DONE) begin
                                issue_stop(step, st);
                            end else begin
                                xfer_pos++;
                                if (xfer_pos >= xfer_total) begin
                                    issue_stop(step, i2crts_pkg::ST_DONE);
                                end else begin
                                    put_cmd(step, i2crts_pkg::CMD_WRITE,
                                            tx_buffer[xfer_pos[3:0]]);
                                end
                            end
                        end
                        SEQ_RESTART: begin
                            if (st != i2crts_pkg::ST_DONE) begin
                                end_xfer(step, st);
                            end else begin
                                put_cmd(step, i2crts_pkg::CMD_WRITE, {xfer_dev, 1'b1});
                                seq_phase = SEQ_ADDR_RD;
                            end
                        end
                        SEQ_ADDR_RD: begin
                            if (st != i2crts_pkg::ST_DONE) begin
                                issue_stop(step, st);
                            end else begin
                                xfer_pos = '0;
                                put_cmd(step, (xfer_total <= 5'd1) ? i2crts_pkg::CMD_RD_NAK
                                                                   : i2crts_pkg::CMD_RD_ACK,
                                        8'h00);
                                seq_phase = SEQ_RD_DATA;
                            end
                        end
                        SEQ_RD_DATA: begin
                            if (st != i2crts_pkg::ST_DONE) begin
                                end_xfer(step, st);
                            end else begin
                                step.rd_valid = 1'b1;
                                step.rd_byte = it.data_byte;
                                step.rd_index = xfer_pos[3:0];
                                xfer_pos++;
                                if (xfer_pos >= xfer_total) begin
                                    issue_stop(step, i2crts_pkg::ST_DONE);
                                end else begin
                                    put_cmd(step, (int'(xfer_pos) + 1 >= int'(xfer_total)) ?
                                            i2crts_pkg::CMD_RD_NAK : i2crts_pkg::CMD_RD_ACK,
                                            8'h00);
                                end
                            end
                        end
                        default: begin
                            end_xfer(step, xfer_held);
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
        if (produced) work_items++;
    endtask

    always @(posedge i_clk) begin
        i2crts_pkg::t_item seen;
        t_bus_step         step;
        t_bus_step         got;
        t_bus_step         want;
        bit                produced;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            seen = '0;
            seen.opcode = i_s_axis_tuser;
            seen.is_read = i_s_axis_tdata[0];
            seen.slave_addr = i_s_axis_tdata[7:1];
            seen.reg_addr = i_s_axis_tdata[15:8];
            seen.byte_count = i_s_axis_tdata[20:16];
            seen.buf_index = i_s_axis_tdata[24:21];
            seen.data_byte = i_s_axis_tdata[32:25];
            seen.flag_nak = i_s_axis_tdata[33];
            seen.flag_arb_lost = i_s_axis_tdata[34];
            seen.flag_error = i_s_axis_tdata[35];
            advance_sequencer(seen, produced, step);
            if (produced) pending_bus_steps.push_back(step);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.cmd_valid = o_m_axis_tdata[0];
            got.cmd_code = o_m_axis_tdata[3:1];
            got.cmd_byte = o_m_axis_tdata[11:4];
            got.rd_valid = o_m_axis_tdata[12];
            got.rd_byte = o_m_axis_tdata[20:13];
            got.rd_index = o_m_axis_tdata[24:21];
            got.xfer_done = o_m_axis_tdata[25];
            got.status = o_m_axis_tdata[27:26];
            if (pending_bus_steps.size() == 0) begin
                note_mismatch($sformatf("unexpected result %h", o_m_axis_tdata));
            end else begin
                want = pending_bus_steps.pop_front();
                check_field("cmd_valid", int'(got.cmd_valid), int'(want.cmd_valid));
                check_field("cmd_code", int'(got.cmd_code), int'(want.cmd_code));
                check_field("cmd_byte", int'(got.cmd_byte), int'(want.cmd_byte));
                check_field("rd_valid", int'(got.rd_valid), int'(want.rd_valid));
                check_field("rd_byte", int'(got.rd_byte), int'(want.rd_byte));
                check_field("rd_index", int'(got.rd_index), int'(want.rd_index));
                check_field("xfer_done", int'(got.xfer_done), int'(want.xfer_done));
                check_field("status", int'(got.status), int'(want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The receiver takes one result per handshake after a random pause, and
    // holds off for a long stretch whenever a test asks for it.
    initial begin
        int gap;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_off > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (hold_off) @(negedge i_clk);
                hold_off = 0;
            end
            gap = int'($urandom_range(0, gap_max));
            if (gap > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    function automatic i2crts_pkg::t_item random_item();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(i2crts_pkg::t_item)-1:0];
    endfunction

    task automatic send_item(input i2crts_pkg::t_item it);
        int gap;
        gap = int'($urandom_range(0, gap_max));
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = {4'b0000, it.flag_error, it.flag_arb_lost, it.flag_nak, it.data_byte,
                          it.buf_index, it.byte_count, it.reg_addr, it.slave_addr, it.is_read};
        i_s_axis_tuser = it.opcode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Plays the bus controller until the open transfer has ended; now and then a
    // load, an unused opcode or a request that arrives while busy slips in between.
    task automatic complete_transfer(input int fail_pct);
        i2crts_pkg::t_item it;
        while (seq_phase != SEQ_IDLE) begin
            if ($urandom_range(0, 99) < 4) begin
                it = random_item();
                if (it.opcode == i2crts_pkg::OP_RESP) it.opcode = i2crts_pkg::OP_LOAD;
                send_item(it);
            end
            it = random_item();
            it.opcode = i2crts_pkg::OP_RESP;
            if (int'($urandom_range(0, 99)) < fail_pct) begin
                {it.flag_nak, it.flag_arb_lost, it.flag_error} = 3'($urandom_range(1, 7));
            end else begin
                {it.flag_nak, it.flag_arb_lost, it.flag_error} = 3'b000;
            end
            send_item(it);
        end
    endtask

    task automatic run_transfer(input logic rd, input logic [6:0] dev, input logic [7:0] regb,
                                input logic [4:0] count, input int fail_pct);
        i2crts_pkg::t_item it;
        it = random_item();
        it.opcode = i2crts_pkg::OP_REQ;
        it.is_read = rd;
        it.slave_addr = dev;
        it.reg_addr = regb;
        it.byte_count = count;
        send_item(it);
        complete_transfer(fail_pct);
    endtask

    task automatic test_buffer_preload();
        i2crts_pkg::t_item it;
        for (int k = 0; k < BUF_SLOTS; k++) begin
            it = random_item();
            it.opcode = i2crts_pkg::OP_LOAD;
            it.buf_index = 4'(k);
            if (k == 0) it.data_byte = 8'h00;
            else if (k == BUF_SLOTS - 1) it.data_byte = 8'hFF;
            send_item(it);
        end
    endtask

    task automatic test_ignored_items();
        i2crts_pkg::t_item it;
        it = random_item();
        it.opcode = i2crts_pkg::OP_RESP;
        send_item(it);
        it = random_item();
        it.opcode = OP_SPARE;
        send_item(it);
        it = random_item();
        it.opcode = i2crts_pkg::OP_REQ;
        it.is_read = 1'b0;
        it.byte_count = 5'd2;
        send_item(it);
        it = random_item();
        it.opcode = i2crts_pkg::OP_REQ;
        send_item(it);
        complete_transfer(0);
    endtask

    task automatic test_edge_transfers();
        i2crts_pkg::t_item it;
        run_transfer(1'b0, 7'h7F, 8'hFF, 5'd0, 0);
        run_transfer(1'b1, 7'h00, 8'h00, 5'd0, 0);
        it = random_item();
        it.opcode = i2crts_pkg::OP_REQ;
        send_item(it);
        it = random_item();
        it.opcode = i2crts_pkg::OP_RESP;
        {it.flag_nak, it.flag_arb_lost, it.flag_error} = 3'b111;
        send_item(it);
    endtask

    task automatic test_output_stall();
        hold_off = STALL_CYCLES;
        run_transfer(1'b0, 7'($urandom), 8'($urandom), 5'd16, 0);
        run_transfer(1'b1, 7'($urandom), 8'($urandom), 5'd31, 0);
    endtask

    task automatic test_random_traffic();
        int                pick;
        int                goal;
        logic [4:0]        cnt;
        i2crts_pkg::t_item it;
        goal = work_items + RANDOM_ITEMS;
        while (work_items < goal) begin
            gap_max = ($urandom_range(0, 7) == 0) ? 0 : 5;
            pick = int'($urandom_range(0, 99));
            if (pick < 6) begin
                repeat ($urandom_range(1, 4)) send_item(random_item());
                complete_transfer(5);
            end else if (pick < 16) begin
                it = random_item();
                it.opcode = i2crts_pkg::OP_LOAD;
                send_item(it);
            end else begin
                pick = int'($urandom_range(0, 99));
                if (pick < 85) cnt = 5'($urandom_range(0, 4));
                else if (pick < 95) cnt = 5'($urandom_range(5, 16));
                else cnt = 5'($urandom_range(17, 31));
                run_transfer(1'($urandom), 7'($urandom), 8'($urandom), cnt, 6);
            end
        end
        gap_max = 5;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = i2crts_pkg::OP_LOAD;
        seq_phase = SEQ_IDLE;
        xfer_read = 1'b0;
        xfer_dev = '0;
        xfer_reg = '0;
        xfer_total = '0;
        xfer_pos = '0;
        xfer_held = i2crts_pkg::ST_DONE;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_buffer_preload();
        test_ignored_items();
        test_edge_transfers();
        test_output_stall();
        test_random_traffic();

        i_s_axis_tvalid = 1'b0;
        while (pending_bus_steps.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_bus_steps.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", pending_bus_steps.size()));
        end
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/i2crts_pkg.sv
src/i2crts_ctrl.sv
src/i2c_register_transfer_sequencer_top.sv
src/i2crts_chk.sv
bench/testbench.sv
